// ===== hdl/plrm_pkg.sv =====
// ----------------------------------------------------------------------------
// plrm_pkg - shared types and constants for the piecewise-linear rank map
// Widths of the breakpoint table, item fields and the divider.
// ----------------------------------------------------------------------------
package plrm_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_W       = 32;
    localparam int RANK_W      = 17;
    localparam int PROD_W      = KEY_W + RANK_W;
    localparam int QUO_W       = RANK_W;
    localparam int STEP_W      = $clog2(QUO_W + 1);

    localparam logic [RANK_W-1:0] RANK_ONE  = RANK_W'(65536);
    localparam logic [RANK_W-1:0] RANK_ZERO = '0;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_MAP   = 1'b1;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
    } mem_wr_t;

endpackage

// ===== hdl/plrm_mem.sv =====
// ----------------------------------------------------------------------------
// plrm_mem - breakpoint table storage
// Key and rank arrays, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plrm_mem
(
    input  logic                          clk,
    input  plrm_pkg::mem_wr_t             wr,
    input  logic [plrm_pkg::IDX_W-1:0]    rd_addr,
    output logic [plrm_pkg::KEY_W-1:0]    rd_key,
    output logic [plrm_pkg::RANK_W-1:0]   rd_rank
);

    logic [plrm_pkg::KEY_W-1:0]  key_mem  [plrm_pkg::TABLE_DEPTH];
    logic [plrm_pkg::RANK_W-1:0] rank_mem [plrm_pkg::TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            key_mem[wr.addr]  <= wr.key;
            rank_mem[wr.addr] <= wr.rank;
        end
        rd_key  <= key_mem[rd_addr];
        rd_rank <= rank_mem[rd_addr];
    end

endmodule

// ===== hdl/plrm_div.sv =====
// ----------------------------------------------------------------------------
// plrm_div - iterative restoring divider
// One quotient bit per cycle; the quotient is known to fit QUO_W bits.
// ----------------------------------------------------------------------------
module plrm_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [plrm_pkg::PROD_W-1:0]   dividend,
    input  logic [plrm_pkg::KEY_W-1:0]    divisor,
    output logic                          done,
    output logic [plrm_pkg::QUO_W-1:0]    quotient
);

    logic [plrm_pkg::KEY_W-1:0]  rem_reg;
    logic [plrm_pkg::QUO_W-1:0]  low_reg;
    logic [plrm_pkg::KEY_W-1:0]  div_reg;
    logic [plrm_pkg::STEP_W-1:0] step_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [plrm_pkg::KEY_W:0]    trial;

    // remainder stays below divisor, so one shifted bit and a subtract per step
    assign trial = {rem_reg, low_reg[plrm_pkg::QUO_W-1]} - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (step_reg == plrm_pkg::STEP_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= plrm_pkg::STEP_W'(plrm_pkg::QUO_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == plrm_pkg::STEP_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[plrm_pkg::PROD_W-1 -: plrm_pkg::KEY_W];
            low_reg <= dividend[plrm_pkg::QUO_W-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[plrm_pkg::KEY_W])
            begin
                rem_reg <= trial[plrm_pkg::KEY_W-1:0];
                low_reg <= {low_reg[plrm_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[plrm_pkg::KEY_W-2:0], low_reg[plrm_pkg::QUO_W-1]};
                low_reg <= {low_reg[plrm_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

// ===== hdl/piecewise_linear_rank_map.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_rank_map - breakpoint table with linear interpolation
// Stores Q16.16 keys with Q1.16 ranks and maps samples to interpolated ranks.
// ----------------------------------------------------------------------------
// A write item (tuser = 0) stores one breakpoint and gives
// no result. A map item (tuser = 1) gives one rank: 0 at or below key 0,
// 65536 at or above the last valid key, otherwise a truncated linear
// interpolation between the first key above the sample and the one before it.
// Items are handled one at a time. A map item first makes the end checks
// against entry 0 and the last entry; at or below key 0 or at or above the
// last key it goes straight to the output register. Otherwise it scans the
// entries from entry 1 upward through the single read port of the table
// memory, then takes a multiply step, the divider (start, 17 quotient bits,
// done) and a load of the output register. The next item is taken once the
// rank is in the output register; a stalled output register holds the block
// until it drains. A finished rank sits in the output register while the
// next item is taken.
// entry_count may only be written while the block is idle; values below 2
// act as 2 and above 256 as 256.
// ----------------------------------------------------------------------------
module piecewise_linear_rank_map
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: entry_count[8:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // entry_index[7:0], sample_value[39:8], entry_rank[56:40]
    input  logic [0:0]  s_axis_tuser,  // func[0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // rank[16:0]
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_OUT
    } state_t;

    state_t                          state_reg;
    logic [plrm_pkg::CNT_W-1:0]      count_reg;
    logic signed [plrm_pkg::KEY_W-1:0] sample_reg;
    logic [plrm_pkg::IDX_W-1:0]      idx_reg;
    logic [plrm_pkg::KEY_W-1:0]      lo_key_reg;
    logic [plrm_pkg::RANK_W-1:0]     lo_rank_reg;
    logic [plrm_pkg::KEY_W-1:0]      hi_key_reg;
    logic [plrm_pkg::RANK_W-1:0]     hi_rank_reg;
    logic [plrm_pkg::PROD_W-1:0]     prod_reg;
    logic [plrm_pkg::KEY_W-1:0]      span_reg;
    logic                            neg_reg;
    logic                            div_start_reg;
    logic [plrm_pkg::RANK_W-1:0]     res_reg;
    logic                            out_valid_reg;
    logic [plrm_pkg::RANK_W-1:0]     out_rank_reg;

    // table ports
    plrm_pkg::mem_wr_t               mem_wr;
    logic [plrm_pkg::IDX_W-1:0]      rd_addr;
    logic [plrm_pkg::KEY_W-1:0]      rd_key;
    logic [plrm_pkg::RANK_W-1:0]     rd_rank;

    logic                            in_acc;
    logic [plrm_pkg::CNT_W-1:0]      n_clamp;
    logic [plrm_pkg::IDX_W-1:0]      last_idx;
    logic                            key_gt;   // table key > sample
    logic                            key_le0;  // sample <= table key
    logic [plrm_pkg::KEY_W-1:0]      dx;
    logic [plrm_pkg::RANK_W-1:0]     rdiff;
    logic                            div_done;
    logic [plrm_pkg::QUO_W-1:0]      quo;
    logic signed [plrm_pkg::RANK_W+1:0] res_wide;
    logic [plrm_pkg::RANK_W-1:0]     res_sat;
    logic                            out_free;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // effective count clamped to 2 .. TABLE_DEPTH
    always_comb
    begin
        if (count_reg < plrm_pkg::CNT_W'(2))
            n_clamp = plrm_pkg::CNT_W'(2);
        else if (count_reg > plrm_pkg::CNT_W'(plrm_pkg::TABLE_DEPTH))
            n_clamp = plrm_pkg::CNT_W'(plrm_pkg::TABLE_DEPTH);
        else
            n_clamp = count_reg;
    end
    assign last_idx = plrm_pkg::IDX_W'(n_clamp - 1'b1);

    // writes go straight into the table
    assign mem_wr.en   = in_acc && (s_axis_tuser[0] == plrm_pkg::FUNC_WRITE);
    assign mem_wr.addr = s_axis_tdata[7:0];
    assign mem_wr.key  = s_axis_tdata[39:8];
    assign mem_wr.rank = s_axis_tdata[56:40];

    assign key_gt  = $signed(rd_key) > sample_reg;
    assign key_le0 = sample_reg <= $signed(rd_key);

    // read address for the data seen in the next state
    always_comb
    begin
        case (state_reg)
            S_CHK_FIRST: rd_addr = last_idx;
            S_CHK_LAST:  rd_addr = plrm_pkg::IDX_W'(1);
            S_SCAN:      rd_addr = idx_reg + 1'b1;
            default:     rd_addr = '0;
        endcase
    end

    plrm_mem u_mem
    (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_rank (rd_rank)
    );

    // interpolation terms; dx is non-negative by the search order, rdiff is the rank magnitude
    assign dx    = sample_reg - lo_key_reg;
    assign rdiff = (hi_rank_reg >= lo_rank_reg) ? hi_rank_reg - lo_rank_reg
                                                : lo_rank_reg - hi_rank_reg;

    plrm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        if (neg_reg)
            res_wide = $signed({2'b00, lo_rank_reg}) - $signed({2'b00, quo});
        else
            res_wide = $signed({2'b00, lo_rank_reg}) + $signed({2'b00, quo});
        if (res_wide < 0)
            res_sat = plrm_pkg::RANK_ZERO;
        else if (res_wide > $signed({2'b00, plrm_pkg::RANK_ONE}))
            res_sat = plrm_pkg::RANK_ONE;
        else
            res_sat = res_wide[plrm_pkg::RANK_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= plrm_pkg::CNT_W'(2);
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= (state_reg == S_MUL);
            if (cfg_valid && cfg_ready)
                count_reg <= cfg_data;
            // load on a finished rank, clear once the result is taken
            if ((state_reg == S_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && (s_axis_tuser[0] == plrm_pkg::FUNC_MAP))
                        state_reg <= S_CHK_FIRST;
                end
                S_CHK_FIRST:
                begin
                    if (key_le0)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_CHK_LAST;
                end
                S_CHK_LAST:
                begin
                    if (!key_gt)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (key_gt || idx_reg == last_idx)
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                sample_reg <= s_axis_tdata[39:8];
                idx_reg    <= plrm_pkg::IDX_W'(1);
            end
            S_CHK_FIRST:
            begin
                lo_key_reg  <= rd_key;
                lo_rank_reg <= rd_rank;
                res_reg     <= plrm_pkg::RANK_ZERO;
            end
            S_CHK_LAST:
            begin
                res_reg <= plrm_pkg::RANK_ONE;
            end
            S_SCAN:
            begin
                if (key_gt || idx_reg == last_idx)
                begin
                    hi_key_reg  <= rd_key;
                    hi_rank_reg <= rd_rank;
                end
                else
                begin
                    lo_key_reg  <= rd_key;
                    lo_rank_reg <= rd_rank;
                    idx_reg     <= idx_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                prod_reg <= dx * rdiff;
                span_reg <= hi_key_reg - lo_key_reg;
                neg_reg  <= hi_rank_reg < lo_rank_reg;
            end
            S_DIV:
            begin
                if (div_done)
                    res_reg <= res_sat;
            end
            S_OUT:
            begin
                if (out_free)
                    out_rank_reg <= res_reg;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_rank_reg};

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for piecewise_linear_rank_map
// Table-driven directed items, then random table builds and sample maps,
// all checked against an in-bench interpolation predictor.
// ----------------------------------------------------------------------------
module tb;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    piecewise_linear_rank_map u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // entry_index[7:0], sample_value[39:8], entry_rank[56:40]
        .s_axis_tuser  (s_axis_tuser),  // func[0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)   // rank[16:0]
    );

    // predictor copy of the table and register
    logic signed [plrm_pkg::KEY_W-1:0] key_tbl [plrm_pkg::TABLE_DEPTH];
    logic [plrm_pkg::RANK_W-1:0]       rank_tbl [plrm_pkg::TABLE_DEPTH];
    int unsigned                       count_reg;

    logic [plrm_pkg::RANK_W-1:0] rank_q[$];
    int                          errors;
    logic                        quiet;     // long stretch with no idling

    typedef struct {
        logic                              fn;
        logic [7:0]                        idx;
        logic signed [plrm_pkg::KEY_W-1:0] smp;
        logic [plrm_pkg::RANK_W-1:0]       rk;
        int                                want;  // -1: use predictor
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("tb NOT OK");
        $finish;
    end

    function automatic logic [plrm_pkg::RANK_W-1:0] interp_rank(
        logic signed [plrm_pkg::KEY_W-1:0] s);
        int unsigned       n;
        int unsigned       i;
        longint            dx;
        longint            span;
        longint            rl;
        longint            rh;
        longint            res;
        n = count_reg < 2 ? 2 : (count_reg > plrm_pkg::TABLE_DEPTH ?
                                 plrm_pkg::TABLE_DEPTH : count_reg);
        if (s <= key_tbl[0])
            return plrm_pkg::RANK_ZERO;
        if (s >= key_tbl[n-1])
            return plrm_pkg::RANK_ONE;
        i = 1;
        while (i < n - 1 && key_tbl[i] <= s)
            i++;
        dx   = longint'(s) - longint'(key_tbl[i-1]);
        span = longint'(key_tbl[i]) - longint'(key_tbl[i-1]);
        if (span == 0)
            span = 1;
        rl = rank_tbl[i-1];
        rh = rank_tbl[i];
        if (rh >= rl)
            res = rl + (dx * (rh - rl)) / span;
        else
            res = rl - (dx * (rl - rh)) / span;
        if (res < 0)
            return plrm_pkg::RANK_ZERO;
        if (res > 65536)
            return plrm_pkg::RANK_ONE;
        return res[plrm_pkg::RANK_W-1:0];
    endfunction

    // valid stays high after an accepted item unless the sender idles
    task automatic send_item(input logic fn, input logic [7:0] idx,
                             input logic signed [plrm_pkg::KEY_W-1:0] smp,
                             input logic [plrm_pkg::RANK_W-1:0] rk, input int want);
        if (!quiet && $urandom_range(99) < 28)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (!quiet && $urandom_range(99) < 28)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {7'd0, rk, smp, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (fn == plrm_pkg::FUNC_WRITE)
        begin
            key_tbl[idx]  = smp;
            rank_tbl[idx] = rk;
        end
        else
        begin
            if (want >= 0 && plrm_pkg::RANK_W'(want) != interp_rank(smp))
            begin
                $error("rank: expected %0d predicted %0d", want, interp_rank(smp));
                errors++;
            end
            rank_q.push_back(want >= 0 ? plrm_pkg::RANK_W'(want) : interp_rank(smp));
        end
    endtask

    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        while (rank_q.size() != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
    endtask

    task automatic write_count(input int unsigned v);
        drain_all();
        cfg_valid <= 1'b1;
        cfg_data  <= 9'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        count_reg = v;
    endtask

    // sorted table with random keys and non-decreasing ranks, but for random jumps in wild tables (some above one)
    task automatic load_table(input int unsigned n, input bit wild);
        longint k;
        int     r;
        k = -longint'($urandom_range(2000000000));
        r = $urandom_range(30000);
        for (int i = 0; i < n; i++)
        begin
            send_item(plrm_pkg::FUNC_WRITE, 8'(i), plrm_pkg::KEY_W'(k),
                      plrm_pkg::RANK_W'(r), -1);
            k += wild ? $urandom_range(1, 32'd4000000000 / n) : $urandom_range(1, 300);
            if (k > 2147483647)
                k = 2147483647 - (n - i);
            r = wild && $urandom_range(5) == 0 ? $urandom_range(131071)
                                               : r + $urandom_range(500);
            if (r > 131071)
                r = 131071;
        end
    endtask

    // output side: random stall, checks against oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (rank_q.size() == 0)
                begin
                    $error("rank item with no expectation: %0d", m_axis_tdata[16:0]);
                    errors++;
                end
                else
                begin
                    if (m_axis_tdata[16:0] !== rank_q[0])
                    begin
                        $error("rank: expected %0d actual %0d", rank_q[0], m_axis_tdata[16:0]);
                        errors++;
                    end
                    void'(rank_q.pop_front());
                end
            end
            m_axis_tready <= quiet || ($urandom_range(99) >= 28);
        end
    end

    initial
    begin
        row_t        rows[$];
        int unsigned n;
        logic signed [plrm_pkg::KEY_W-1:0] smp;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 9'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        quiet = 1'b0;
        errors = 0;
        count_reg = 2;
        foreach (key_tbl[i])
        begin
            key_tbl[i] = '0;
            rank_tbl[i] = '0;
        end
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: count stays 2 after reset
        rows = '{
            '{plrm_pkg::FUNC_WRITE, 8'd0, 32'sh8000_0000, 17'd0, -1},
            '{plrm_pkg::FUNC_WRITE, 8'd1, 32'sh7FFF_FFFF, 17'd65536, -1},
            '{plrm_pkg::FUNC_MAP, 8'hFF, 32'sh8000_0000, 17'h1FFFF, 0},
            '{plrm_pkg::FUNC_MAP, 8'd0, 32'sh7FFF_FFFF, 17'd0, 65536},
            '{plrm_pkg::FUNC_MAP, 8'd0, 32'sh0000_0000, 17'd0, -1},
            '{plrm_pkg::FUNC_MAP, 8'd0, 32'sh8000_0001, 17'd0, 0},
            '{plrm_pkg::FUNC_MAP, 8'd0, 32'sh7FFF_FFFE, 17'd0, -1},
            // decreasing ranks
            '{plrm_pkg::FUNC_WRITE, 8'd0, -32'sd100, 17'd60000, -1},
            '{plrm_pkg::FUNC_WRITE, 8'd1, 32'sd100, 17'd1000, -1},
            '{plrm_pkg::FUNC_MAP, 8'd0, 32'sd37, 17'd0, -1},
            '{plrm_pkg::FUNC_MAP, 8'd0, -32'sd99, 17'd0, -1},
            // stored ranks above one saturate
            '{plrm_pkg::FUNC_WRITE, 8'd0, 32'sd0, 17'h1FFFF, -1},
            '{plrm_pkg::FUNC_WRITE, 8'd1, 32'sd10, 17'h1FFFF, -1},
            '{plrm_pkg::FUNC_MAP, 8'd0, 32'sd5, 17'd0, 65536},
            '{plrm_pkg::FUNC_WRITE, 8'd255, 32'sd50, 17'd3, -1},
            '{plrm_pkg::FUNC_MAP, 8'd255, 32'sd0, 17'd0, 0}
        };
        foreach (rows[i])
            send_item(rows[i].fn, rows[i].idx, rows[i].smp, rows[i].rk, rows[i].want);

        // count 0 acts as 2; count above the table acts as the full table
        write_count(0);
        send_item(plrm_pkg::FUNC_MAP, 8'd0, 32'sd3, 17'd0, -1);
        load_table(256, 1'b1);
        write_count(511);
        for (int i = 0; i < 20; i++)
            send_item(plrm_pkg::FUNC_MAP, 8'($urandom), $urandom, 17'($urandom), -1);
        write_count(256);
        for (int i = 0; i < 20; i++)
            send_item(plrm_pkg::FUNC_MAP, 8'($urandom), $urandom, 17'($urandom), -1);
        write_count(1);
        send_item(plrm_pkg::FUNC_MAP, 8'd0, 32'sd3, 17'd0, -1);

        // random phases: small tables mostly, wild ones sometimes
        for (int ph = 0; ph < 25; ph++)
        begin
            quiet = (ph >= 10 && ph < 14);
            n = ($urandom_range(7) == 0) ? $urandom_range(2, 256) : $urandom_range(2, 12);
            write_count(2);
            load_table(n, $urandom_range(1));
            write_count(n);
            for (int i = 0; i < 30; i++)
            begin
                if ($urandom_range(2) == 0)
                    smp = $urandom;
                else
                    smp = key_tbl[$urandom_range(n - 1)] + $signed(32'($urandom_range(600)) - 300);
                send_item(plrm_pkg::FUNC_MAP, 8'($urandom), smp, 17'($urandom), -1);
            end
            if (ph == 20)
                drain_all();
        end
        quiet = 1'b0;

        drain_all();
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/plrm_pkg.sv
hdl/plrm_mem.sv
hdl/plrm_div.sv
hdl/piecewise_linear_rank_map.sv
bench/tb.sv
